@@ src/key_debounce_auto_repeat_top_macros.svh @@
// assertion macros shared by the key debounce rtl
// needs signals clk and arst_n in the scope where a macro is used
`ifndef KEY_DEBOUNCE_AUTO_REPEAT_TOP_MACROS_SVH
`define KEY_DEBOUNCE_AUTO_REPEAT_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define KDAR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define KDAR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define KDAR_ASSERT_IMP(lbl, ante, cons, msg)
`define KDAR_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/kdar_pkg.sv @@
// types and constants of the key debounce with auto-repeat block
// no dependencies
`timescale 1ns / 1ps

package kdar_pkg;

	localparam int KEY_BITS       = 8;
	localparam int CFG_BITS       = 8;
	localparam int CFG_INDEX_BITS = 2;

	localparam int CODE_BITS_DEF  = 8;
	localparam int COUNT_BITS_DEF = 8;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_PRESS_DELAY  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_REPEAT_LIMIT = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_REPEAT_STYLE = 2'd2;

	// repeat styles
	localparam logic STYLE_KEY   = 1'b0;
	localparam logic STYLE_TOUCH = 1'b1;

	localparam logic [CFG_BITS-1:0] PRESS_DELAY_RST  = 8'd5;
	localparam logic [CFG_BITS-1:0] REPEAT_LIMIT_RST = 8'd3;
	localparam logic                REPEAT_STYLE_RST = STYLE_KEY;

	typedef struct packed {
		logic [KEY_BITS-1:0] key_sample;
		logic                second_tick;
	} kdar_in_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key_code;
		logic                is_repeat;
	} kdar_out_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] press_delay;
		logic [CFG_BITS-1:0] repeat_limit;
		logic                repeat_style;
	} kdar_cfg_t;

endpackage

@@ src/key_debounce_auto_repeat_top.sv @@
// Key debounce with auto-repeat. One scan sample (key code plus one-second tick
// flag) is accepted per clock while the input is not stalled. The sample sits in
// the input register, where its state update and report decision are made, and a
// report, if any, is captured in the output register when the sample moves on.
// The sustained rate is one sample per clock; the input stalls only while a
// report waits in the output register and out_ready is low.
// depends on kdar_pkg, kdar_track and the assertion macro header
`timescale 1ns / 1ps
`include "key_debounce_auto_repeat_top_macros.svh"

module key_debounce_auto_repeat_top
	import kdar_pkg::*;
#(
	parameter int CODE_BITS  = CODE_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  kdar_in_t                  in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output kdar_out_t                 out_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]       cfg_data
);

	kdar_cfg_t           cfg_q;
	kdar_in_t            data_s1;
	logic                valid_s1;
	logic                out_valid_q;
	kdar_out_t           out_q;
	logic                advance;
	logic                emit, emit_repeat;
	logic [KEY_BITS-1:0] emit_code;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_delay  <= PRESS_DELAY_RST;
			cfg_q.repeat_limit <= REPEAT_LIMIT_RST;
			cfg_q.repeat_style <= REPEAT_STYLE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PRESS_DELAY:  cfg_q.press_delay  <= cfg_data;
				REG_REPEAT_LIMIT: cfg_q.repeat_limit <= cfg_data;
				REG_REPEAT_STYLE: cfg_q.repeat_style <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// the staged sample moves on whenever the output register can take a report
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	kdar_track #(
		.CODE_BITS  (CODE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.sample      (data_s1),
		.cfg         (cfg_q),
		.emit        (emit),
		.emit_repeat (emit_repeat),
		.emit_code   (emit_code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q.key_code  <= emit_code;
			out_q.is_repeat <= emit_repeat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a report never carries the no-key code
	`KDAR_ASSERT_IMP(a_code_nonzero, out_valid_q, out_q.key_code != '0,
		"report with zero key code")
	// input backpressure only comes from a stalled report
	`KDAR_ASSERT_IMP(a_stall_cause, !in_ready, valid_s1 && out_valid_q && !out_ready,
		"input stalled without a waiting report")
	// a stalled report stays put
	`KDAR_ASSERT_NXT(a_out_hold, out_valid_q && !out_ready, out_valid_q && $stable(out_q),
		"waiting report dropped or changed")

endmodule

@@ src/kdar_track.sv @@
// debounce and auto-repeat state tracker: state registers and their update
// depends on kdar_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "key_debounce_auto_repeat_top_macros.svh"

module kdar_track
	import kdar_pkg::*;
#(
	parameter int CODE_BITS  = CODE_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  kdar_in_t            sample,
	input  kdar_cfg_t           cfg,
	output logic                emit,
	output logic                emit_repeat,
	output logic [KEY_BITS-1:0] emit_code
);

	localparam int CW = (CODE_BITS < KEY_BITS) ? CODE_BITS : KEY_BITS;
	localparam int WW = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
	localparam logic [WW-1:0] CMAX = WW'((1 << COUNT_BITS) - 1);

	logic [CW-1:0]         last_q, held_q, last_d, held_d, code;
	logic [COUNT_BITS-1:0] stable_q, repeat_q, stable_d, repeat_d;
	logic [COUNT_BITS-1:0] delay, limit;
	logic [WW-1:0]         delay_w, limit_w;

	assign code    = sample.key_sample[CW-1:0];
	assign delay_w = WW'(cfg.press_delay);
	assign limit_w = WW'(cfg.repeat_limit);
	// settings beyond the counter range saturate so a count never wraps
	assign delay   = (delay_w > CMAX) ? COUNT_BITS'(CMAX) : COUNT_BITS'(delay_w);
	assign limit   = (limit_w > CMAX) ? COUNT_BITS'(CMAX) : COUNT_BITS'(limit_w);
	assign emit_code = KEY_BITS'(code);

	always_comb begin
		last_d      = last_q;
		held_d      = held_q;
		stable_d    = stable_q;
		repeat_d    = repeat_q;
		emit        = 1'b0;
		emit_repeat = 1'b0;
		if (code == '0) begin
			last_d   = '0;
			held_d   = '0;
			stable_d = '0;
			repeat_d = '0;
		end else begin
			last_d = code;
			if (code != last_q) begin
				held_d   = '0;
				stable_d = '0;
				repeat_d = '0;
			end else if (stable_q < delay) begin
				stable_d = stable_q + COUNT_BITS'(1);
				held_d   = '0;
			end else if (held_q == '0) begin
				held_d = code;
				emit   = 1'b1;
			end else if (cfg.repeat_style == STYLE_KEY) begin
				if (code != held_q) begin
					held_d = code;
				end else if (sample.second_tick) begin
					if (repeat_q < limit) begin
						repeat_d = repeat_q + COUNT_BITS'(1);
					end else begin
						emit        = 1'b1;
						emit_repeat = 1'b1;
					end
				end
			end else begin
				if (repeat_q < limit) begin
					repeat_d = repeat_q + COUNT_BITS'(1);
				end else begin
					repeat_d    = '0;
					emit        = 1'b1;
					emit_repeat = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= '0;
			held_q   <= '0;
			stable_q <= '0;
			repeat_q <= '0;
		end else if (advance) begin
			last_q   <= last_d;
			held_q   <= held_d;
			stable_q <= stable_d;
			repeat_q <= repeat_d;
		end
	end

	// a held code is always the code last sampled
	`KDAR_ASSERT_IMP(a_held_is_last, held_q != '0, held_q == last_q,
		"held code differs from last sample")
	// a first-press report only comes when nothing is held yet
	`KDAR_ASSERT_IMP(a_first_unheld, emit && !emit_repeat, held_q == '0,
		"first press reported while a code is held")
	// after a first-press transaction the code is held
	`KDAR_ASSERT_NXT(a_first_latches, advance && emit && !emit_repeat, held_q != '0,
		"code not held after first press")

endmodule
